/* src/stride_scheduler_macros.svh */
// Assertion helpers shared by the stride scheduler RTL.
`ifndef STRIDE_SCHEDULER_MACROS_SVH
`define STRIDE_SCHEDULER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STSCH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STSCH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/stsch_pkg.sv */
package stsch_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_ADDED        = 3'd0,
    ST_SCHEDULED    = 3'd1,
    ST_FULL         = 3'd2,
    ST_ZERO_TICKETS = 3'd3,
    ST_EMPTY        = 3'd4
  } status_t;

  // Operations of the shared arithmetic unit.
  typedef enum logic [0:0] {
    ALU_SUB = 1'b0,
    ALU_ADD = 1'b1
  } alu_op_t;

  // Input word.
  typedef struct packed {
    logic        kind;
    logic [7:0]  process_id;
    logic [15:0] tickets;
  } in_t;

  // Result word.
  typedef struct packed {
    status_t     status;
    logic [3:0]  winner_slot;
    logic [7:0]  winner_id;
    logic [31:0] winner_pass;
    logic [31:0] winner_wins;
  } out_t;

  // One row of the process table.
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] stride;
    logic [31:0] pass;
    logic [31:0] wins;
  } entry_t;

  // Request to and answer from the shared arithmetic unit.
  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        flag;
  } alu_rsp_t;

  // Input kinds.
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [0:0]  REG_NUMERATOR = 1'b0;
  localparam logic [15:0] NUMERATOR_RESET = 16'd10000;

  // Restoring divide of a 16-bit numerator takes one step per quotient bit.
  localparam int unsigned DIV_STEPS = 16;

endpackage

/* src/stsch_alu.sv */
// Shared arithmetic unit: a 32-bit subtract that reports the borrow, or a
// 32-bit add that saturates at the top of the range and reports the carry.
module stsch_alu (
  input  stsch_pkg::alu_req_t req,
  output stsch_pkg::alu_rsp_t rsp
);
  import stsch_pkg::*;

  logic [32:0] diff;
  logic [32:0] sum;

  assign diff = {1'b0, req.a} - {1'b0, req.b};
  assign sum  = {1'b0, req.a} + {1'b0, req.b};

  // Select the operation; a carry out of the add pins the result to all ones.
  always_comb begin
    unique case (req.op)
      ALU_SUB: begin
        rsp.value = diff[31:0];
        rsp.flag  = diff[32];
      end
      ALU_ADD: begin
        rsp.flag  = sum[32];
        rsp.value = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
      default: begin
        rsp.value = diff[31:0];
        rsp.flag  = diff[32];
      end
    endcase
  end

endmodule

/* src/stride_scheduler.sv */
// Stride scheduler over a table of up to MAX_PROCESSES processes.
// Input channel (in_valid, in_stall, in_data): an add word stores a process id
// with stride = numerator / tickets; a tick word picks the entry with the
// lowest pass value (the newest entry on ties), adds its stride to its pass
// value and counts a win. Every input word gives exactly one result word on
// the output channel (out_valid, out_stall, out_data).
// One input word is worked on at a time; in_stall is high while it is busy.
// An add runs a restoring division on the shared subtractor, then writes the
// new table row and hands the result off. In a tick the table memory is read
// one row a cycle and the shared subtractor compares each pass value with
// the best so far, then the same unit forms the saturated pass and win counts.
// Rejected adds and ticks on an empty table go straight to the handoff.
// In every case the result becomes valid in the same cycle in which the next
// word can be taken.
// The result sits in an output register, so the next word is accepted while
// the receiver stalls; a finished word waits only if that register is full
// and the receiver stalls. Reset empties the table and sets the numerator to
// 10000. The numerator is written through the APB port at byte address 0.
module stride_scheduler #(
  parameter int unsigned MAX_PROCESSES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  stsch_pkg::in_t                       in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output stsch_pkg::out_t                      out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [stsch_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [stsch_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [stsch_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                 pready
);
  import stsch_pkg::*;

  `include "stride_scheduler_macros.svh"

  localparam int unsigned SLOT_W = $clog2(MAX_PROCESSES);
  localparam int unsigned CNT_W  = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_ADDW = 7'b0000100,
    S_SCAN = 7'b0001000,
    S_PASS = 7'b0010000,
    S_WINS = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [15:0]       numerator;
  logic [CNT_W-1:0]  count;
  logic              in_fire;
  status_t           start_status;

  // Division registers.
  logic [15:0]       div_tickets;
  logic [15:0]       num_sh;
  logic [15:0]       rem;
  logic [15:0]       quo;
  logic [16:0]       rem_sh;
  logic [STEP_W-1:0] step;
  logic [7:0]        add_id;

  // Scan registers.
  logic [SLOT_W-1:0] scan_addr;
  logic [SLOT_W-1:0] rd_slot;
  logic              scan_more;
  logic              cmp_ok;
  logic              have_best;
  entry_t            best;
  logic [SLOT_W-1:0] best_slot;
  logic [31:0]       new_pass;

  // Table memory.
  entry_t            mem [MAX_PROCESSES];
  entry_t            rd_data;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  entry_t            wr_data;

  out_t              res;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  stsch_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Configuration port: one register, no wait states.
  assign pready = 1'b1;

  always_comb begin
    if (paddr[CFG_ADDR_W-1:2] == REG_NUMERATOR) begin
      prdata = {16'b0, numerator};
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      numerator <= NUMERATOR_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[CFG_ADDR_W-1:2] == REG_NUMERATOR) begin
      numerator <= pwdata[15:0];
    end
  end

  // Input handshake: a word is taken only when the sequencer is idle.
  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign rem_sh   = {rem, num_sh[15]};

  // Status known at acceptance; a tick that runs is marked scheduled later.
  always_comb begin
    start_status = ST_ADDED;
    if (in_data.kind == KIND_ADD) begin
      if (in_data.tickets == 16'd0) begin
        start_status = ST_ZERO_TICKETS;
      end else if (count >= CNT_W'(MAX_PROCESSES)) begin
        start_status = ST_FULL;
      end
    end else if (count == '0) begin
      start_status = ST_EMPTY;
    end
  end

  // Operand selection for the shared unit.
  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = '0;
    alu_req.b  = '0;
    unique case (state)
      S_DIV: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = {15'b0, rem_sh};
        alu_req.b  = {16'b0, div_tickets};
      end
      S_SCAN: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = rd_data.pass;
        alu_req.b  = best.pass;
      end
      S_PASS: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = best.pass;
        alu_req.b  = {16'b0, best.stride};
      end
      S_WINS: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = best.wins;
        alu_req.b  = 32'd1;
      end
      default: begin
        alu_req.op = ALU_SUB;
      end
    endcase
  end

  // Table writes: a new row after the divide, the updated winner after a tick.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_slot;
    wr_data = best;
    unique case (state)
      S_ADDW: begin
        wr_en   = 1'b1;
        wr_addr = SLOT_W'(count);
        wr_data = '{id: add_id, stride: quo, pass: 32'd0, wins: 32'd0};
      end
      S_WINS: begin
        wr_en   = 1'b1;
        wr_addr = best_slot;
        wr_data = '{id: best.id, stride: best.stride, pass: new_pass,
                    wins: alu_rsp.value};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[scan_addr];
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.kind == KIND_ADD) begin
            if (in_data.tickets == 16'd0 || count >= CNT_W'(MAX_PROCESSES)) begin
              state_next = S_EMIT;
            end else begin
              state_next = S_DIV;
            end
          end else if (count == '0) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = S_ADDW;
        end
      end
      S_ADDW: begin
        state_next = S_EMIT;
      end
      S_SCAN: begin
        if (!scan_more && cmp_ok) begin
          state_next = S_PASS;
        end
      end
      S_PASS: begin
        state_next = S_WINS;
      end
      S_WINS: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ADDW) begin
        count <= count + 1'b1;
      end
      if (state == S_EMIT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          res <= '{status: start_status, winner_slot: 4'd0, winner_id: 8'd0,
                   winner_pass: 32'd0, winner_wins: 32'd0};
          add_id      <= in_data.process_id;
          div_tickets <= in_data.tickets;
          num_sh      <= numerator;
          rem         <= '0;
          step        <= '0;
          scan_addr   <= SLOT_W'(count - 1'b1);
          scan_more   <= 1'b1;
          cmp_ok      <= 1'b0;
          have_best   <= 1'b0;
        end
      end
      S_DIV: begin
        // One quotient bit per cycle; keep the difference when it did not borrow.
        if (!alu_rsp.flag) begin
          rem <= alu_rsp.value[15:0];
        end else begin
          rem <= rem_sh[15:0];
        end
        quo    <= {quo[14:0], !alu_rsp.flag};
        num_sh <= {num_sh[14:0], 1'b0};
        step   <= step + 1'b1;
      end
      S_ADDW: begin
        res.winner_slot <= 4'(count);
        res.winner_id   <= add_id;
      end
      S_SCAN: begin
        // Strictly lower pass values replace the best, so the newest wins ties.
        if (cmp_ok && (!have_best || alu_rsp.flag)) begin
          best      <= rd_data;
          best_slot <= rd_slot;
          have_best <= 1'b1;
        end
        if (scan_more) begin
          rd_slot <= scan_addr;
          cmp_ok  <= 1'b1;
          if (scan_addr == '0) begin
            scan_more <= 1'b0;
          end else begin
            scan_addr <= scan_addr - 1'b1;
          end
        end else begin
          cmp_ok <= 1'b0;
        end
      end
      S_PASS: begin
        new_pass <= alu_rsp.value;
      end
      S_WINS: begin
        res <= '{status: ST_SCHEDULED, winner_slot: 4'(best_slot),
                 winner_id: best.id, winner_pass: best.pass,
                 winner_wins: alu_rsp.value};
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_data <= res;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks on the sequencer and the table.
  `STSCH_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(MAX_PROCESSES), "table count overflow")
  `STSCH_ASSERT_NEXT(a_add_count, state == S_ADDW, count == $past(count) + 1'b1, "add not counted")
  `STSCH_ASSERT_NOW(a_best_slot, state == S_PASS, CNT_W'(best_slot) < count, "winner beyond table")
  `STSCH_ASSERT_NOW(a_div_rem, state == S_DIV, rem < div_tickets, "divide remainder too large")
  `STSCH_ASSERT_NEXT(a_emit_out, state == S_EMIT && (!out_valid || !out_stall), out_valid, "result lost")

endmodule

/* test/tb_stride_scheduler.sv */
module tb_stride_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import stsch_pkg::*;

  localparam int SLOTS = 16;
  localparam logic [CFG_ADDR_W-1:0] NUMERATOR_ADDR = {REG_NUMERATOR, 2'b00};
  // First byte address past the numerator; writes there must be ignored.
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = 3'd4;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASE_WORDS = 300;

  // One row of a stimulus script: either a register write or a word sent
  // reps times, optionally with its result typed in.
  typedef struct {
    bit                    register_write;
    logic [CFG_ADDR_W-1:0] addr;
    logic [31:0]           value;
    in_t                   word;
    int                    reps;
    bit                    typed;
    out_t                  result;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Scheduler state as the testbench predicts it.
  logic [15:0] numerator = NUMERATOR_RESET;
  logic [7:0]  proc_id[SLOTS];
  logic [15:0] proc_stride[SLOTS];
  logic [31:0] proc_pass[SLOTS];
  logic [31:0] proc_wins[SLOTS];
  int          proc_count = 0;

  out_t expected_results[$];
  int   mismatch_count = 0;
  bit   idle_on = 1'b1;
  int   burst_left = 0;
  int   holds_asked = 0;
  int   holds_done = 0;

  stride_scheduler #(.MAX_PROCESSES(SLOTS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predict the result of one word and update the predicted table.
  function automatic out_t schedule_word(in_t w);
    out_t        r;
    int          best;
    logic [32:0] sum;
    r = '0;
    if (w.kind == KIND_ADD) begin
      if (w.tickets == 0) begin
        r.status = ST_ZERO_TICKETS;
      end else if (proc_count >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        proc_id[proc_count]     = w.process_id;
        proc_stride[proc_count] = numerator / w.tickets;
        proc_pass[proc_count]   = '0;
        proc_wins[proc_count]   = '0;
        r.status      = ST_ADDED;
        r.winner_slot = 4'(proc_count);
        r.winner_id   = w.process_id;
        proc_count++;
      end
    end else if (proc_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // Walk from the newest entry down; strict less keeps the newest on ties.
      best = proc_count - 1;
      for (int s = proc_count - 2; s >= 0; s--) begin
        if (proc_pass[s] < proc_pass[best]) best = s;
      end
      sum = proc_pass[best] + proc_stride[best];
      r.status      = ST_SCHEDULED;
      r.winner_slot = 4'(best);
      r.winner_id   = proc_id[best];
      r.winner_pass = proc_pass[best];
      proc_pass[best] = sum[32] ? '1 : sum[31:0];
      if (proc_wins[best] != '1) proc_wins[best]++;
      r.winner_wins = proc_wins[best];
    end
    return r;
  endfunction

  function automatic step_t word_row(logic kind, logic [7:0] id, logic [15:0] tickets,
                                     int reps = 1);
    step_t row;
    row = '{default: '0};
    row.word.kind       = kind;
    row.word.process_id = id;
    row.word.tickets    = tickets;
    row.reps            = reps;
    return row;
  endfunction

  function automatic step_t typed_row(logic kind, logic [7:0] id, logic [15:0] tickets,
                                      status_t st, logic [3:0] slot, logic [7:0] rid,
                                      logic [31:0] pass, logic [31:0] wins);
    step_t row;
    row = word_row(kind, id, tickets);
    row.typed              = 1'b1;
    row.result.status      = st;
    row.result.winner_slot = slot;
    row.result.winner_id   = rid;
    row.result.winner_pass = pass;
    row.result.winner_wins = wins;
    return row;
  endfunction

  function automatic step_t register_row(logic [CFG_ADDR_W-1:0] addr, logic [31:0] value);
    step_t row;
    row = '{default: '0};
    row.register_write = 1'b1;
    row.addr           = addr;
    row.value          = value;
    return row;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Offer one word, in bursts with random gaps, and record its result.
  task automatic send_word(input in_t w, input bit typed, input out_t want);
    int   gap;
    out_t guess;
    gap = 0;
    if (idle_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 2) != 0) gap = $urandom_range(1, 10);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    guess = schedule_word(w);
    expected_results.push_back(typed ? want : guess);
    if (burst_left > 0) burst_left--;
  endtask

  // Stop sending and wait until every expected result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Write a register, then read the numerator back.
  task automatic access_register(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == NUMERATOR_ADDR) numerator = value[15:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= NUMERATOR_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    compare_field("numerator readback", 32'(numerator), 32'(prdata[15:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_script(input step_t rows[$]);
    foreach (rows[i]) begin
      if (rows[i].register_write) begin
        drain_results();
        access_register(rows[i].addr, rows[i].value);
      end else begin
        // Long repeated runs go at full rate to keep the run short.
        idle_on = (rows[i].reps < 100);
        repeat (rows[i].reps) send_word(rows[i].word, rows[i].typed, rows[i].result);
        idle_on = 1'b1;
      end
    end
  endtask

  // Receiver: stalls in segments of random density, and holds off for a long
  // stretch whenever one is asked for.
  initial begin : receiver
    int seg;
    int pct;
    forever begin
      if (holds_done != holds_asked) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        seg = $urandom_range(1, 24);
        pct = 0;
        if (idle_on && $urandom_range(0, 3) != 0) pct = $urandom_range(10, 80);
        repeat (seg) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  // Compare every taken result with the oldest expectation.
  always @(posedge clk) begin : result_check
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: %p", $time, out_data);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("status", 32'(want.status), 32'(out_data.status));
        compare_field("winner_slot", 32'(want.winner_slot), 32'(out_data.winner_slot));
        compare_field("winner_id", 32'(want.winner_id), 32'(out_data.winner_id));
        compare_field("winner_pass", want.winner_pass, out_data.winner_pass);
        compare_field("winner_wins", want.winner_wins, out_data.winner_wins);
      end
    end
  end

  initial begin : stimulus
    step_t       script[$];
    in_t         w;
    int          pick;
    int unsigned setting;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Opening: empty and rejected words, then one entry with the largest
    // stride before anything else joins the table.
    script.push_back(typed_row(KIND_TICK, 8'h00, 16'h0000, ST_EMPTY, 4'd0, 8'h00,
                               32'd0, 32'd0));
    script.push_back(typed_row(KIND_ADD, 8'hFF, 16'h0000, ST_ZERO_TICKETS, 4'd0, 8'h00,
                               32'd0, 32'd0));
    script.push_back(register_row(NUMERATOR_ADDR, 32'd65535));
    script.push_back(typed_row(KIND_ADD, 8'h00, 16'h0001, ST_ADDED, 4'd0, 8'h00,
                               32'd0, 32'd0));
    script.push_back(typed_row(KIND_TICK, 8'hFF, 16'hFFFF, ST_SCHEDULED, 4'd0, 8'h00,
                               32'd0, 32'd1));
    // A write past the numerator must leave the stride at 65535 / 3.
    script.push_back(register_row(SPARE_ADDR, 32'd7));
    script.push_back(typed_row(KIND_ADD, 8'h5A, 16'd3, ST_ADDED, 4'd1, 8'h5A,
                               32'd0, 32'd0));
    script.push_back(typed_row(KIND_TICK, 8'h00, 16'h0000, ST_SCHEDULED, 4'd1, 8'h5A,
                               32'd0, 32'd1));
    script.push_back(word_row(KIND_TICK, 8'h00, 16'h0000));
    script.push_back(register_row(NUMERATOR_ADDR, 32'd10000));
    script.push_back(word_row(KIND_ADD, 8'h81, 16'd7));
    script.push_back(word_row(KIND_ADD, 8'h7E, 16'd2));
    script.push_back(word_row(KIND_TICK, 8'h00, 16'h0000, 3));
    run_script(script);

    // Random phases: mostly ticks, a few adds while slots remain, and some
    // zero-ticket adds. Two slots are kept for the closing script.
    for (int p = 0; p < 4; p++) begin
      setting = (p == 0) ? 65535 : (p == 3) ? 10000 : $urandom_range(2, 65535);
      drain_results();
      access_register(NUMERATOR_ADDR, setting);
      idle_on = (p != 2);
      if (p == 1) holds_asked++;
      repeat (PHASE_WORDS) begin
        pick         = $urandom_range(0, 99);
        w.kind       = KIND_TICK;
        w.process_id = 8'($urandom);
        w.tickets    = 16'($urandom);
        if (pick < 3) begin
          w.kind    = KIND_ADD;
          w.tickets = '0;
        end else if (pick < 6 && proc_count < SLOTS - 2) begin
          w.kind    = KIND_ADD;
          w.tickets = 16'($urandom_range(1, numerator));
        end
        send_word(w, 1'b0, '0);
      end
    end
    idle_on = 1'b1;
    while (proc_count < SLOTS - 2) begin
      w.kind       = KIND_ADD;
      w.process_id = 8'($urandom);
      w.tickets    = 16'($urandom_range(1, numerator));
      send_word(w, 1'b0, '0);
    end

    // Closing: smallest numerators, a zero stride that then wins every tick,
    // and a full table.
    script.delete();
    script.push_back(register_row(NUMERATOR_ADDR, 32'd1));
    script.push_back(typed_row(KIND_ADD, 8'hC3, 16'd1, ST_ADDED, 4'd14, 8'hC3,
                               32'd0, 32'd0));
    script.push_back(word_row(KIND_TICK, 8'h00, 16'h0000));
    script.push_back(register_row(NUMERATOR_ADDR, 32'd0));
    script.push_back(typed_row(KIND_ADD, 8'h3C, 16'hFFFF, ST_ADDED, 4'd15, 8'h3C,
                               32'd0, 32'd0));
    script.push_back(typed_row(KIND_TICK, 8'h00, 16'h0000, ST_SCHEDULED, 4'd15, 8'h3C,
                               32'd0, 32'd1));
    script.push_back(typed_row(KIND_TICK, 8'hFF, 16'h0000, ST_SCHEDULED, 4'd15, 8'h3C,
                               32'd0, 32'd2));
    script.push_back(typed_row(KIND_ADD, 8'h11, 16'd5, ST_FULL, 4'd0, 8'h00,
                               32'd0, 32'd0));
    script.push_back(typed_row(KIND_ADD, 8'h22, 16'd0, ST_ZERO_TICKETS, 4'd0, 8'h00,
                               32'd0, 32'd0));
    run_script(script);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
